@@ rtl/core/ptb_pkg.sv @@
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, constants and elaboration-time tables for the stereo tone
// burst core: register indexes, controller commands, pitch and sine tables.
// ----------------------------------------------------------------------------
package ptb_pkg;

   // Fixed synthesis constants of the oscillator
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int PHASE_BITS       = 32;
   localparam int SAMPLE_RATE_HZ   = 44100;

   localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_QUARTER  = SINE_TABLE_DEPTH / 4;
   localparam int TURN_SHIFT    = 32 - SINE_IDX_BITS;

   // Pitch quotient spans notes 36..96
   localparam int NOTE_SPAN = 61;
   localparam int Q_BITS    = 6;

   // Shared divider sizes
   localparam int DIV_NUM_BITS = 38;
   localparam int DIV_DEN_BITS = 32;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VALUE_MIN      = 3'd0,
      CSR_VALUE_MAX      = 3'd1,
      CSR_NOTE_LENGTH    = 3'd2,
      CSR_ATTACK_LENGTH  = 3'd3,
      CSR_RELEASE_LENGTH = 3'd4,
      CSR_PEAK_AMPLITUDE = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PITCH_L,
      ST_WAIT_L,
      ST_PITCH_R,
      ST_WAIT_R,
      ST_BEGIN,
      ST_CHECK,
      ST_ENV_WAIT,
      ST_SINE_L,
      ST_SHAPE_L,
      ST_SINE_R,
      ST_SHAPE_R,
      ST_OUT
   } ctl_state_type;

   typedef struct packed {
      logic load_req;
      logic side;          // 0 left, 1 right
      logic div_pitch;
      logic div_env;
      logic store_step;
      logic note_begin;
      logic note_end;
      logic amp_from_div;
      logic amp_from_peak;
      logic sine_load;
      logic shape_store;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic op_tick;
      logic pitch_direct;
      logic div_done;
      logic tick_skip;
      logic env_divide;
      logic out_free;
   } ctl_status_type;

   typedef logic [PHASE_BITS-1:0] phase_type;
   typedef phase_type step_table_type [NOTE_SPAN];
   typedef logic [14:0] mag_type;
   typedef mag_type sine_table_type [SINE_QUARTER];

   localparam longint unsigned TOP_OCTAVE_Q16 [12] = '{
      64'd137167144, 64'd0, 64'd153964914, 64'd0, 64'd172819773, 64'd0,
      64'd0, 64'd205518503, 64'd0, 64'd230686720, 64'd0, 64'd0};
   localparam int SCALE_SNAP [12] = '{0, 0, 2, 2, 4, 4, 4, 7, 7, 9, 9, 0};
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned Q30_ONE     = 64'd1 << 30;

   // Phase step for each pitch quotient, snapped to the pentatonic scale
   function automatic step_table_type build_step_table();
      step_table_type   tab;
      int               note;
      int               oct;
      int               pc;
      int               snapped;
      longint unsigned  num;
      longint unsigned  mask;
      mask = (64'd1 << PHASE_BITS) - 64'd1;
      for (int q = 0; q < NOTE_SPAN; q++) begin
         note    = 36 + q;
         oct     = note / 12;
         pc      = note % 12;
         snapped = oct * 12 + SCALE_SNAP[pc] + ((pc == 11) ? 12 : 0);
         oct     = snapped / 12;
         pc      = snapped % 12;
         num     = TOP_OCTAVE_Q16[pc] << (PHASE_BITS - 24 + oct);
         tab[q]  = phase_type'(((num + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ) & mask);
      end
      return tab;
   endfunction

   // Quarter-wave sine magnitude in Q15 by a truncated Taylor series
   function automatic mag_type sine_mag(input int f);
      longint unsigned r;
      longint unsigned a;
      longint unsigned a2;
      longint unsigned t;
      longint unsigned s;
      r  = longint'(f) << TURN_SHIFT;
      a  = (r * HALF_PI_Q30) >> 30;
      a2 = (a * a) >> 30;
      t  = Q30_ONE - a2 / 72;
      t  = Q30_ONE - ((a2 * t) >> 30) / 42;
      t  = Q30_ONE - ((a2 * t) >> 30) / 20;
      t  = Q30_ONE - ((a2 * t) >> 30) / 6;
      s  = (a * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return mag_type'(s);
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      for (int f = 0; f < SINE_QUARTER; f++) begin
         tab[f] = sine_mag(f);
      end
      return tab;
   endfunction

   localparam step_table_type STEP_TABLE = build_step_table();
   localparam sine_table_type SINE_TABLE = build_sine_table();
   localparam mag_type        SINE_PEAK  = sine_mag(SINE_QUARTER);

endpackage

@@ rtl/core/pentatonic_stereo_tone_burst_core.sv @@
// ----------------------------------------------------------------------------
// pentatonic_stereo_tone_burst_core
// Stereo tone burst generator: start beats set two pentatonic pitches, tick
// beats during a note return one enveloped stereo sine sample each.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata {right_value, left_value}, tuser operation
//  rsp      out  rsp_tvalid/tready    tdata {right_sample, left_sample}, tlast last
//  csr      in   csr_we               csr_index, csr_wdata
//
//  A start beat waits twice on the shared bit-serial divider (38 quotient
//  bits) for pitch scaling, and skips it when the bounds are equal or
//  inverted. A tick beat waits on the divider on attack or release, not on
//  the envelope plateau, and a tick that gives no sample ends at the check.
//  One beat is in work at a time; req_tready is high only when idle. The
//  result sits in an output register, so a stalled rsp blocks only the next
//  tick's final load. Reset is synchronous and restores register defaults.
// ----------------------------------------------------------------------------
module pentatonic_stereo_tone_burst_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ptb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ptb_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,   // left_value, right_value
   input  logic                               req_tuser,   // operation
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,   // left_sample, right_sample
   output logic                               rsp_tlast
);

   ptb_pkg::ctl_cmd_type    cmd;
   ptb_pkg::ctl_status_type status;

   ptb_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ptb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

@@ rtl/core/ptb_divider.sv @@
// ----------------------------------------------------------------------------
// ptb_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptb_divider #(
   parameter int NUM_BITS = ptb_pkg::DIV_NUM_BITS,
   parameter int DEN_BITS = ptb_pkg::DIV_DEN_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient
);

   localparam int CW = $clog2(NUM_BITS + 1);

   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   shifted;
   logic [DEN_BITS:0]   den_ext;

   assign den_ext = {1'b0, den_ff};
   assign shifted = {rem_ff[DEN_BITS-1:0], quo_ff[NUM_BITS-1]};

   // Shift in one dividend bit, subtract when the divisor fits
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = numer;
         den_in   = denom;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= den_ext) begin
            rem_in = shifted - den_ext;
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         count_in = count_ff + CW'(1);
         if (count_ff == CW'(NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/ptb_datapath.sv @@
// ----------------------------------------------------------------------------
// ptb_datapath
// Registers, pitch mapping, envelope, sine lookup and output beat register.
// ----------------------------------------------------------------------------
module ptb_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ptb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ptb_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic [63:0]                         req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,
   output logic                                rsp_tlast,
   input  ptb_pkg::ctl_cmd_type                cmd,
   output ptb_pkg::ctl_status_type             status
);

   localparam int IB = ptb_pkg::SINE_IDX_BITS;
   localparam int PB = ptb_pkg::PHASE_BITS;

   // Configuration registers
   logic signed [31:0] vmin_ff, vmax_ff;
   logic [11:0]        nlen_ff, alen_ff, rlen_ff;
   logic [14:0]        peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vmin_ff <= 32'sd0;
         vmax_ff <= 32'sd255;
         nlen_ff <= 12'd2205;
         alen_ff <= 12'd220;
         rlen_ff <= 12'd661;
         peak_ff <= 15'd16000;
      end else if (csr_we) begin
         case (ptb_pkg::csr_index_type'(csr_index))
            ptb_pkg::CSR_VALUE_MIN:      vmin_ff <= csr_wdata;
            ptb_pkg::CSR_VALUE_MAX:      vmax_ff <= csr_wdata;
            ptb_pkg::CSR_NOTE_LENGTH:    nlen_ff <= csr_wdata[11:0];
            ptb_pkg::CSR_ATTACK_LENGTH:  alen_ff <= csr_wdata[11:0];
            ptb_pkg::CSR_RELEASE_LENGTH: rlen_ff <= csr_wdata[11:0];
            ptb_pkg::CSR_PEAK_AMPLITUDE: peak_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Captured request beat
   logic signed [31:0] lval_ff, rval_ff;
   logic               op_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         lval_ff <= req_tdata[31:0];
         rval_ff <= req_tdata[63:32];
         op_ff   <= req_tuser;
      end
   end

   // Pitch mapping: clamp and scale to a quotient over the value range
   logic signed [32:0] lo33, hi33, v33, range33;
   logic [31:0]        diff32;
   logic [ptb_pkg::DIV_NUM_BITS-1:0] pitch_num;
   logic               pitch_direct;

   assign lo33    = {vmin_ff[31], vmin_ff};
   assign hi33    = {vmax_ff[31], vmax_ff};
   assign v33     = cmd.side ? {rval_ff[31], rval_ff} : {lval_ff[31], lval_ff};
   assign range33 = hi33 - lo33;
   assign pitch_direct = range33[32] || (range33 == 33'sd0);

   always_comb begin
      logic signed [32:0] d;
      d = v33 - lo33;
      if (v33 < lo33) begin
         diff32 = '0;
      end else if (v33 > hi33) begin
         diff32 = range33[31:0];
      end else begin
         diff32 = d[31:0];
      end
   end

   assign pitch_num = ptb_pkg::DIV_NUM_BITS'(diff32) * ptb_pkg::DIV_NUM_BITS'(60);

   // Envelope segment decode on the running sample index
   logic [11:0]        idx_ff;
   logic               active_ff;
   logic               in_attack, in_release, tick_skip;
   logic signed [13:0] rel_thresh;
   logic [11:0]        env_b, env_den;
   logic [26:0]        env_prod;
   logic [12:0]        idx_next;

   assign idx_next   = {1'b0, idx_ff} + 13'd1;
   assign tick_skip  = !active_ff || (idx_ff >= nlen_ff);
   assign in_attack  = (alen_ff != 12'd0) && (idx_ff < alen_ff);
   assign rel_thresh = $signed({2'b00, nlen_ff}) - $signed({2'b00, rlen_ff});
   assign in_release = (rlen_ff != 12'd0) && ($signed({2'b00, idx_ff}) > rel_thresh);
   assign env_b      = in_attack ? idx_ff : (nlen_ff - idx_ff);
   assign env_den    = in_attack ? alen_ff : rlen_ff;
   assign env_prod   = 27'(peak_ff) * 27'(env_b);

   // Shared divider for pitch scaling and envelope slopes
   logic                             div_done;
   logic [ptb_pkg::DIV_NUM_BITS-1:0] div_quo;
   logic [ptb_pkg::DIV_NUM_BITS-1:0] div_numer;
   logic [ptb_pkg::DIV_DEN_BITS-1:0] div_denom;

   assign div_numer = cmd.div_env ? ptb_pkg::DIV_NUM_BITS'(env_prod) : pitch_num;
   assign div_denom = cmd.div_env ? ptb_pkg::DIV_DEN_BITS'(env_den) : range33[31:0];

   ptb_divider #(
      .NUM_BITS (ptb_pkg::DIV_NUM_BITS),
      .DEN_BITS (ptb_pkg::DIV_DEN_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_pitch | cmd.div_env),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Phase steps from the pitch quotient
   logic [ptb_pkg::Q_BITS-1:0] q_sel;
   ptb_pkg::phase_type         lstep_ff, rstep_ff;

   always_comb begin
      if (!pitch_direct) begin
         q_sel = div_quo[ptb_pkg::Q_BITS-1:0];
      end else if (range33 == 33'sd0) begin
         q_sel = '0;
      end else begin
         q_sel = ptb_pkg::Q_BITS'(ptb_pkg::NOTE_SPAN - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lstep_ff <= '0;
         rstep_ff <= '0;
      end else if (cmd.store_step) begin
         if (cmd.side) begin
            rstep_ff <= ptb_pkg::STEP_TABLE[q_sel];
         end else begin
            lstep_ff <= ptb_pkg::STEP_TABLE[q_sel];
         end
      end
   end

   // Sine lookup: fold the phase to a quarter wave
   ptb_pkg::phase_type  lphase_ff, rphase_ff, phase_sel;
   logic [IB-1:0]       sidx;
   logic [IB-3:0]       kidx;
   logic [IB-2:0]       fidx;
   ptb_pkg::mag_type    mag, mag_ff;
   logic                neg_ff;

   assign phase_sel = cmd.side ? rphase_ff : lphase_ff;
   assign sidx      = phase_sel[PB-1 -: IB];
   assign kidx      = sidx[IB-3:0];
   assign fidx      = sidx[IB-2] ? ((IB-1)'(ptb_pkg::SINE_QUARTER) - {1'b0, kidx})
                                 : {1'b0, kidx};
   assign mag       = fidx[IB-2] ? ptb_pkg::SINE_PEAK : ptb_pkg::SINE_TABLE[fidx[IB-3:0]];

   always_ff @(posedge clock) begin
      if (cmd.sine_load) begin
         mag_ff <= mag;
         neg_ff <= sidx[IB-1];
      end
   end

   // Envelope amplitude and shaped samples
   logic [14:0] amp_ff;
   logic [29:0] shape_prod;
   logic [15:0] shaped;
   logic [15:0] lsamp_ff, rsamp_ff;

   assign shape_prod = 30'(amp_ff) * 30'(mag_ff);
   assign shaped     = neg_ff ? (16'd0 - {1'b0, shape_prod[29:15]}) : {1'b0, shape_prod[29:15]};

   always_ff @(posedge clock) begin
      if (cmd.amp_from_div) begin
         amp_ff <= div_quo[14:0];
      end else if (cmd.amp_from_peak) begin
         amp_ff <= peak_ff;
      end
      if (cmd.shape_store) begin
         if (cmd.side) begin
            rsamp_ff <= shaped;
         end else begin
            lsamp_ff <= shaped;
         end
      end
   end

   // Note state: begin, end, advance on each delivered sample
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         lphase_ff <= '0;
         rphase_ff <= '0;
      end else if (cmd.note_begin) begin
         active_ff <= 1'b1;
         idx_ff    <= '0;
         lphase_ff <= '0;
         rphase_ff <= '0;
      end else if (cmd.note_end) begin
         active_ff <= 1'b0;
      end else if (cmd.out_load) begin
         idx_ff    <= idx_next[11:0];
         lphase_ff <= lphase_ff + lstep_ff;
         rphase_ff <= rphase_ff + rstep_ff;
         if (idx_next >= {1'b0, nlen_ff}) begin
            active_ff <= 1'b0;
         end
      end
   end

   // Output beat register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {rsamp_ff, lsamp_ff};
         rsp_last_ff <= (idx_next == {1'b0, nlen_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.op_tick      = (ptb_pkg::op_type'(op_ff) == ptb_pkg::OP_TICK);
   assign status.pitch_direct = pitch_direct;
   assign status.div_done     = div_done;
   assign status.tick_skip    = tick_skip;
   assign status.env_divide   = in_attack | in_release;
   assign status.out_free     = !rsp_valid_ff || rsp_tready;

`ifndef SYNTHESIS
   a_out_load_valid : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("output beat not held after load");

   a_note_begin : assert property (@(posedge clock) disable iff (reset)
      cmd.note_begin |=> active_ff && (idx_ff == 12'd0) && (lphase_ff == '0)
                         && (rphase_ff == '0))
      else $error("note start did not clear the burst state");

   a_index_step : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && !cmd.note_begin && !cmd.note_end
      |=> idx_ff == $past(idx_ff) + 12'd1)
      else $error("sample index did not advance by one");
`endif

endmodule

@@ rtl/core/ptb_controller.sv @@
// ----------------------------------------------------------------------------
// ptb_controller
// Sequencer for start and tick beats: drives the datapath by commands.
// ----------------------------------------------------------------------------
module ptb_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  ptb_pkg::ctl_status_type  status,
   output ptb_pkg::ctl_cmd_type     cmd
);

   ptb_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptb_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ptb_pkg::ST_DECODE;
         end
         ptb_pkg::ST_DECODE: begin
            state_in = status.op_tick ? ptb_pkg::ST_CHECK : ptb_pkg::ST_PITCH_L;
         end
         ptb_pkg::ST_PITCH_L: begin
            state_in = status.pitch_direct ? ptb_pkg::ST_PITCH_R : ptb_pkg::ST_WAIT_L;
         end
         ptb_pkg::ST_WAIT_L: begin
            if (status.div_done) state_in = ptb_pkg::ST_PITCH_R;
         end
         ptb_pkg::ST_PITCH_R: begin
            state_in = status.pitch_direct ? ptb_pkg::ST_BEGIN : ptb_pkg::ST_WAIT_R;
         end
         ptb_pkg::ST_WAIT_R: begin
            if (status.div_done) state_in = ptb_pkg::ST_BEGIN;
         end
         ptb_pkg::ST_BEGIN: begin
            state_in = ptb_pkg::ST_IDLE;
         end
         ptb_pkg::ST_CHECK: begin
            if (status.tick_skip) begin
               state_in = ptb_pkg::ST_IDLE;
            end else if (status.env_divide) begin
               state_in = ptb_pkg::ST_ENV_WAIT;
            end else begin
               state_in = ptb_pkg::ST_SINE_L;
            end
         end
         ptb_pkg::ST_ENV_WAIT: begin
            if (status.div_done) state_in = ptb_pkg::ST_SINE_L;
         end
         ptb_pkg::ST_SINE_L:  state_in = ptb_pkg::ST_SHAPE_L;
         ptb_pkg::ST_SHAPE_L: state_in = ptb_pkg::ST_SINE_R;
         ptb_pkg::ST_SINE_R:  state_in = ptb_pkg::ST_SHAPE_R;
         ptb_pkg::ST_SHAPE_R: state_in = ptb_pkg::ST_OUT;
         ptb_pkg::ST_OUT: begin
            if (status.out_free) state_in = ptb_pkg::ST_IDLE;
         end
         default: state_in = ptb_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ptb_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ptb_pkg::ST_PITCH_L: begin
            cmd.store_step = status.pitch_direct;
            cmd.div_pitch  = !status.pitch_direct;
         end
         ptb_pkg::ST_WAIT_L: begin
            cmd.store_step = status.div_done;
         end
         ptb_pkg::ST_PITCH_R: begin
            cmd.side       = 1'b1;
            cmd.store_step = status.pitch_direct;
            cmd.div_pitch  = !status.pitch_direct;
         end
         ptb_pkg::ST_WAIT_R: begin
            cmd.side       = 1'b1;
            cmd.store_step = status.div_done;
         end
         ptb_pkg::ST_BEGIN: begin
            cmd.note_begin = 1'b1;
         end
         ptb_pkg::ST_CHECK: begin
            cmd.note_end      = status.tick_skip;
            cmd.div_env       = !status.tick_skip && status.env_divide;
            cmd.amp_from_peak = !status.tick_skip && !status.env_divide;
         end
         ptb_pkg::ST_ENV_WAIT: begin
            cmd.amp_from_div = status.div_done;
         end
         ptb_pkg::ST_SINE_L: begin
            cmd.sine_load = 1'b1;
         end
         ptb_pkg::ST_SHAPE_L: begin
            cmd.shape_store = 1'b1;
         end
         ptb_pkg::ST_SINE_R: begin
            cmd.side      = 1'b1;
            cmd.sine_load = 1'b1;
         end
         ptb_pkg::ST_SHAPE_R: begin
            cmd.side        = 1'b1;
            cmd.shape_store = 1'b1;
         end
         ptb_pkg::ST_OUT: begin
            cmd.out_load = status.out_free;
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output beat loaded over a pending beat");

   a_env_wait_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptb_pkg::ST_ENV_WAIT) && !status.div_done
      |=> state_ff == ptb_pkg::ST_ENV_WAIT)
      else $error("envelope wait left before the divider finished");

   a_div_single : assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_pitch && cmd.div_env))
      else $error("divider started for pitch and envelope at once");
`endif

endmodule

@@ dv/pentatonic_stereo_tone_burst_checker.sv @@
// ----------------------------------------------------------------------------
// pentatonic_stereo_tone_burst_checker
// Watches the csr, req and rsp channels of the tone burst core, keeps its own
// copy of the pitch, phase and envelope state, predicts every stereo sample
// and compares each rsp beat in order with the oldest predicted sample.
// ----------------------------------------------------------------------------
module pentatonic_stereo_tone_burst_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ptb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ptb_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [63:0]                        req_tdata,   // left_value, right_value
   input  logic                               req_tuser,   // operation
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [31:0]                        rsp_tdata,   // left_sample, right_sample
   input  logic                               rsp_tlast,
   output int                                 pending_count,
   output int                                 error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               last;
   } stereo_sample_type;

   localparam int PENTA_SNAP [12] = '{0, 0, 2, 2, 4, 4, 4, 7, 7, 9, 9, 0};
   localparam longint unsigned OCT8_Q16 [12] = '{
      64'd137167144, 64'd0, 64'd153964914, 64'd0, 64'd172819773, 64'd0,
      64'd0, 64'd205518503, 64'd0, 64'd230686720, 64'd0, 64'd0};
   localparam longint unsigned ONE_Q30    = 64'd1 << 30;
   localparam longint unsigned QUARTER_PI = 64'd1686629713;

   // configuration copy
   logic signed [31:0] lo_bound, hi_bound;
   int                 burst_len, rise_len, fall_len, peak_level;

   // oscillator copy
   logic        burst_on;
   int          sample_pos;
   logic [31:0] step_l, step_r, phase_l, phase_r;

   stereo_sample_type expected_samples [$];

   function automatic logic [31:0] pitch_step(logic signed [31:0] v);
      longint          lo;
      longint          hi;
      longint          span;
      longint          x;
      int              note;
      int              oct;
      int              pc;
      longint unsigned num;
      lo   = lo_bound;
      hi   = hi_bound;
      span = hi - lo;
      x    = v;
      if (span == 0) begin
         note = 36;
      end else if (span < 0) begin
         note = 96;
      end else begin
         if (x < lo) x = lo;
         if (x > hi) x = hi;
         note = 36 + int'(((x - lo) * 60) / span);
      end
      oct  = note / 12;
      pc   = note % 12;
      note = oct * 12 + PENTA_SNAP[pc] + ((pc == 11) ? 12 : 0);
      oct  = note / 12;
      pc   = note % 12;
      num  = OCT8_Q16[pc] << (8 + oct);
      return 32'((num + 64'd22050) / 64'd44100);
   endfunction

   function automatic int sine_of_phase(logic [31:0] phase);
      longint unsigned turn;
      longint unsigned r;
      longint unsigned a;
      longint unsigned a2;
      longint unsigned t;
      longint unsigned s;
      logic [1:0]      quad;
      turn = longint'(phase[31:22]) << 22;
      quad = turn[31:30];
      r    = turn & (ONE_Q30 - 1);
      if (quad[0]) r = ONE_Q30 - r;
      a  = (r * QUARTER_PI) >> 30;
      a2 = (a * a) >> 30;
      t  = ONE_Q30 - a2 / 72;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 6;
      s  = (a * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      return quad[1] ? -int'(s) : int'(s);
   endfunction

   function automatic logic signed [15:0] scale_product(int level, int sn);
      int mag;
      int p;
      mag = (sn < 0) ? -sn : sn;
      p   = (level * mag) >>> 15;
      return 16'((sn < 0) ? -p : p);
   endfunction

   function automatic int envelope_level(int i);
      int level;
      if (rise_len != 0 && i < rise_len) begin
         level = (peak_level * i) / rise_len;
      end else if (fall_len != 0 && i > burst_len - fall_len) begin
         level = (peak_level * (burst_len - i)) / fall_len;
      end else begin
         level = peak_level;
      end
      return (level > 32767) ? 32767 : level;
   endfunction

   always @(posedge clock) begin
      stereo_sample_type got;
      stereo_sample_type want;
      int                level;
      if (reset) begin
         lo_bound   = 0;
         hi_bound   = 255;
         burst_len  = 2205;
         rise_len   = 220;
         fall_len   = 661;
         peak_level = 16000;
         burst_on   = 1'b0;
         sample_pos = 0;
         step_l     = '0;
         step_r     = '0;
         phase_l    = '0;
         phase_r    = '0;
         expected_samples.delete();
         error_count = 0;
      end else begin
         // compare the rsp beat with the oldest sample
         if (rsp_tvalid && rsp_tready) begin
            got.left  = rsp_tdata[15:0];
            got.right = rsp_tdata[31:16];
            got.last  = rsp_tlast;
            if (expected_samples.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%t unexpected rsp beat L=%0d R=%0d last=%0b",
                           $realtime, got.left, got.right, got.last);
            end else begin
               want = expected_samples.pop_front();
               if (got.left !== want.left || got.right !== want.right ||
                   got.last !== want.last) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"%t sample mismatch: exp L=%0d R=%0d last=%0b,",
                               " got L=%0d R=%0d last=%0b"},
                              $realtime, want.left, want.right, want.last,
                              got.left, got.right, got.last);
               end
            end
         end
         // track register writes
         if (csr_we) begin
            case (csr_index)
               ptb_pkg::CSR_VALUE_MIN:      lo_bound   = csr_wdata;
               ptb_pkg::CSR_VALUE_MAX:      hi_bound   = csr_wdata;
               ptb_pkg::CSR_NOTE_LENGTH:    burst_len  = int'(csr_wdata[11:0]);
               ptb_pkg::CSR_ATTACK_LENGTH:  rise_len   = int'(csr_wdata[11:0]);
               ptb_pkg::CSR_RELEASE_LENGTH: fall_len   = int'(csr_wdata[11:0]);
               ptb_pkg::CSR_PEAK_AMPLITUDE: peak_level = int'(csr_wdata[14:0]);
               default: ;
            endcase
         end
         // predict from the req beat
         if (req_tvalid && req_tready) begin
            if (ptb_pkg::op_type'(req_tuser) == ptb_pkg::OP_START) begin
               step_l     = pitch_step(req_tdata[31:0]);
               step_r     = pitch_step(req_tdata[63:32]);
               phase_l    = '0;
               phase_r    = '0;
               sample_pos = 0;
               burst_on   = 1'b1;
            end else if (!burst_on || sample_pos >= burst_len) begin
               burst_on = 1'b0;
            end else begin
               level      = envelope_level(sample_pos);
               want.left  = scale_product(level, sine_of_phase(phase_l));
               want.right = scale_product(level, sine_of_phase(phase_r));
               want.last  = (sample_pos + 1 == burst_len);
               expected_samples.push_back(want);
               phase_l    = phase_l + step_l;
               phase_r    = phase_r + step_r;
               sample_pos = (sample_pos + 1) & 12'hFFF;
               if (sample_pos == 0 || sample_pos >= burst_len) burst_on = 1'b0;
            end
         end
      end
      pending_count = expected_samples.size();
   end

endmodule

@@ dv/pentatonic_stereo_tone_burst_core_tb.sv @@
// ----------------------------------------------------------------------------
// pentatonic_stereo_tone_burst_core_tb
// Drives start and tick beats and register settings into the tone burst core
// with random gaps and rsp stalls; the checker predicts and compares samples.
// ----------------------------------------------------------------------------
module pentatonic_stereo_tone_burst_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [ptb_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ptb_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   int          pending_count;
   int          error_count;
   int          cycle_count = 0;
   int          beats_sent = 0;
   logic        no_idle = 1'b0;
   logic        rsp_enable = 1'b0;

   // cfg mirror for drawing stimulus
   longint      cur_lo = 0;
   longint      cur_hi = 255;
   int          cur_len = 2205;

   always #4 clock = ~clock;

   pentatonic_stereo_tone_burst_core i_dut (.*);

   pentatonic_stereo_tone_burst_checker i_checker (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .pending_count, .error_count);

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // rsp side: random stall per beat
   initial begin
      int stall;
      wait (rsp_enable);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // send one req beat; valid stays high when the next gap is zero
   task automatic send_beat(ptb_pkg::op_type op, logic [31:0] lv, logic [31:0] rv);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {rv, lv};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      beats_sent++;
   endtask

   // hold off until all samples are back and the core is idle
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (150) @(negedge clock);
   endtask

   task automatic put_reg(ptb_pkg::csr_index_type idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic program_regs(longint lo, longint hi, int len, int att, int rel,
                               int peak);
      drain();
      put_reg(ptb_pkg::CSR_VALUE_MIN, 32'(lo));
      put_reg(ptb_pkg::CSR_VALUE_MAX, 32'(hi));
      put_reg(ptb_pkg::CSR_NOTE_LENGTH, 32'(len));
      put_reg(ptb_pkg::CSR_ATTACK_LENGTH, 32'(att));
      put_reg(ptb_pkg::CSR_RELEASE_LENGTH, 32'(rel));
      put_reg(ptb_pkg::CSR_PEAK_AMPLITUDE, 32'(peak));
      csr_we <= 1'b0;
      cur_lo  = lo;
      cur_hi  = hi;
      cur_len = len;
   endtask

   function automatic logic [31:0] pick_value();
      longint span;
      span = cur_hi - cur_lo;
      if ($urandom_range(0, 1) == 0 || span <= 0) return $urandom;
      return 32'(cur_lo + (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF)
                 % (span + 1));
   endfunction

   task automatic play_burst(int ticks);
      send_beat(ptb_pkg::OP_START, pick_value(), pick_value());
      repeat (ticks) send_beat(ptb_pkg::OP_TICK, $urandom, $urandom);
   endtask

   task automatic random_regs();
      longint lo;
      longint hi;
      int     len;
      lo = longint'(signed'(32'($urandom)));
      hi = longint'(signed'(32'($urandom)));
      case ($urandom_range(0, 5))
         0: begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
         1: hi = lo;
         2: if (hi > lo) begin lo = hi; hi = lo - 1; end
         3: begin
            lo = longint'($urandom_range(0, 100)) - 64'sd50;
            hi = lo + longint'($urandom_range(1, 300));
         end
         default: if (hi < lo) begin lo = hi; hi = lo + $urandom_range(0, 1 << 30); end
      endcase
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      len = ($urandom_range(0, 15) == 0) ? 4095 : $urandom_range(1, 24);
      program_regs(lo, hi, len,
                   ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 12),
                   ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 12),
                   ($urandom_range(0, 7) == 0) ? 32767 : $urandom_range(0, 32767));
   endtask

   initial begin
      int ticks;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset      <= 1'b0;
      rsp_enable <= 1'b1;

      // reset settings, extreme values, start during a running note
      send_beat(ptb_pkg::OP_START, 32'h8000_0000, 32'h7FFF_FFFF);
      repeat (3) send_beat(ptb_pkg::OP_TICK, '0, '1);
      send_beat(ptb_pkg::OP_START, 32'd255, 32'd100);
      repeat (2) send_beat(ptb_pkg::OP_TICK, '1, '0);

      // equal bounds, no attack or release, tick past the end of the note
      program_regs(7, 7, 2, 0, 0, 32767);
      send_beat(ptb_pkg::OP_START, 32'd7, 32'h8000_0000);
      repeat (3) send_beat(ptb_pkg::OP_TICK, '0, '0);

      // inverted bounds, long envelope segments, zero peak
      program_regs(100, -100, 3, 4095, 4095, 0);
      send_beat(ptb_pkg::OP_START, 32'd0, 32'd50);
      repeat (3) send_beat(ptb_pkg::OP_TICK, '0, '0);

      // zero note length
      program_regs(-64'sd2147483648, 64'sd2147483647, 0, 1, 1, 16000);
      send_beat(ptb_pkg::OP_START, 32'h0000_0000, 32'hFFFF_FFFF);
      send_beat(ptb_pkg::OP_TICK, '0, '0);

      // note length lowered below the running sample position
      program_regs(0, 60, 10, 2, 3, 20000);
      send_beat(ptb_pkg::OP_START, 32'd11, 32'd59);
      repeat (5) send_beat(ptb_pkg::OP_TICK, '0, '0);
      program_regs(0, 60, 3, 2, 3, 20000);
      repeat (2) send_beat(ptb_pkg::OP_TICK, '0, '0);

      // random bursts, mostly well formed
      while (beats_sent < 440) begin
         if ($urandom_range(0, 5) == 0) random_regs();
         no_idle <= ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 6) != 0) begin
            ticks = (cur_len > 40) ? $urandom_range(5, 30) : cur_len + $urandom_range(0, 2);
            play_burst(ticks);
         end else begin
            repeat ($urandom_range(1, 6))
               send_beat(ptb_pkg::op_type'($urandom_range(0, 1)), $urandom, $urandom);
         end
         if ($urandom_range(0, 9) == 0) drain();
      end

      drain();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
